@@ rtl/core/ils_pkg.sv @@
package ils_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int DEFAULT_DEPTH = 64;
   localparam int POS_WIDTH     = 8;
   localparam int ACTION_WIDTH  = 3;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_READ       = 3'd0,
      ACT_INS_HEAD   = 3'd1,
      ACT_INS_TAIL   = 3'd2,
      ACT_INS_BEFORE = 3'd3,
      ACT_DELETE     = 3'd4
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                  ins_en;
      logic                  del_en;
      logic [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

@@ rtl/core/indexed_list_store.sv @@
// A word accepted on start comes back on the rsp_ ports in the next cycle, from registers.
// Throughput: one word per cycle; busy stays low, since the row of cells shifts
// every element at once and nothing holds the response register.
// The receiver cannot stall; rsp_strobe marks each response for one cycle.
// Synchronous reset empties the list (count zero); element storage is not cleared.
module indexed_list_store #(
   parameter int DEPTH = ils_pkg::DEFAULT_DEPTH,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic        [ils_pkg::ACTION_WIDTH-1:0] req_action,
   input  logic signed [ils_pkg::POS_WIDTH-1:0]    req_position,
   input  logic signed [ils_pkg::DATA_WIDTH-1:0]   req_value,
   output logic                                    rsp_strobe,
   output logic signed [ils_pkg::DATA_WIDTH-1:0]   rsp_read_value,
   output logic        [ils_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic        [CNT_W-1:0]                 rsp_count
);
   import ils_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cell_cmd_type          cmd;
   logic [IDX_W-1:0]      at;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] read_data;

   assign busy      = 1'b0;
   assign read_data = cell_data[at];

   ils_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .action         (req_action),
      .position       (req_position),
      .value          (req_value),
      .read_data      (read_data),
      .cmd            (cmd),
      .at             (at),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ils_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .at         (at),
         .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
         .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
         .data_out   (cell_data[i])
      );
   end

endmodule

@@ rtl/core/ils_cell.sv @@
module ils_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6
) (
   input  logic                           clock,
   input  ils_pkg::cell_cmd_type          cmd,
   input  logic [IDX_W-1:0]               at,
   input  logic [ils_pkg::DATA_WIDTH-1:0] left_data,
   input  logic [ils_pkg::DATA_WIDTH-1:0] right_data,
   output logic [ils_pkg::DATA_WIDTH-1:0] data_out
);
   import ils_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins_en) begin
         if (MY_IDX > at) begin
            data_in = left_data;
         end else if (MY_IDX == at) begin
            data_in = cmd.value;
         end
      end else if (cmd.del_en) begin
         if (MY_IDX >= at) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

@@ rtl/core/ils_ctrl.sv @@
module ils_ctrl #(
   parameter int DEPTH = ils_pkg::DEFAULT_DEPTH,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ils_pkg::ACTION_WIDTH-1:0] action,
   input  logic [ils_pkg::POS_WIDTH-1:0]    position,
   input  logic [ils_pkg::DATA_WIDTH-1:0]   value,
   input  logic [ils_pkg::DATA_WIDTH-1:0]   read_data,
   output ils_pkg::cell_cmd_type            cmd,
   output logic [IDX_W-1:0]                 at,
   output logic                             rsp_strobe,
   output logic [ils_pkg::DATA_WIDTH-1:0]   rsp_read_value,
   output logic [ils_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [CNT_W-1:0]                 rsp_count
);
   import ils_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH) + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    strobe_ff;
   logic [DATA_WIDTH-1:0]   read_value_ff;
   logic [DATA_WIDTH-1:0]   read_value_in;
   status_type              status_ff;
   status_type              status_in;
   logic signed [CMP_W-1:0] pos_s;
   logic signed [CMP_W-1:0] cnt_s;
   logic                    in_range;
   logic                    full;

   assign pos_s    = {{(CMP_W - POS_WIDTH){position[POS_WIDTH-1]}}, position};
   assign cnt_s    = {{(CMP_W - CNT_W){1'b0}}, count_ff};
   assign in_range = !pos_s[CMP_W-1] && (pos_s < cnt_s);
   assign full     = (count_ff >= DEPTH_CNT);

   always_comb begin
      cmd           = '0;
      cmd.value     = value;
      at            = pos_s[IDX_W-1:0];
      count_in      = count_ff;
      status_in     = ST_DONE;
      read_value_in = '1;
      case (action)
         ACT_READ: begin
            if (in_range) begin
               read_value_in = read_data;
            end else begin
               status_in = ST_RANGE;
            end
         end
         ACT_INS_HEAD: begin
            at = '0;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins_en = start;
               count_in   = count_ff + 1'b1;
            end
         end
         ACT_INS_TAIL: begin
            at = count_ff[IDX_W-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins_en = start;
               count_in   = count_ff + 1'b1;
            end
         end
         ACT_INS_BEFORE: begin
            if (pos_s[CMP_W-1]) begin
               at = '0;
            end
            if (pos_s > cnt_s) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins_en = start;
               count_in   = count_ff + 1'b1;
            end
         end
         ACT_DELETE: begin
            if (in_range) begin
               cmd.del_en = start;
               count_in   = count_ff - 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= start;
         if (start) begin
            count_ff <= count_in;
         end
      end
      if (start) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = count_ff;

endmodule
